/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/hld_pkg.sv */
// ----------------------------------------------------------------------------
// hld_pkg
// Types and constants of the header/length/XOR deframer.
// ----------------------------------------------------------------------------
package hld_pkg;

    localparam int LENGTH_BITS = 16;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_SYNC2   = 8'b0000_0010,
        PH_SKIP_A  = 8'b0000_0100,
        PH_SKIP_B  = 8'b0000_1000,
        PH_LEN_LO  = 8'b0001_0000,
        PH_LEN_HI  = 8'b0010_0000,
        PH_PAYLOAD = 8'b0100_0000,
        PH_CHECK   = 8'b1000_0000
    } phase_t;

    // One input beat handed to the parser.
    typedef struct packed {
        logic       valid;
        logic       restart;
        logic [7:0] data;
    } step_t;

    // One frame report.
    typedef struct packed {
        logic        frame_status;
        logic [15:0] payload_length;
        logic [7:0]  computed_checksum;
    } result_t;

endpackage

/* rtl/hld_parser.sv */
// ----------------------------------------------------------------------------
// hld_parser
// Frame state machine: sync hunt, header skip, length, payload XOR, check.
// ----------------------------------------------------------------------------
module hld_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  hld_pkg::step_t    step,
    output logic              res_valid,
    output hld_pkg::result_t  res
);

    hld_pkg::phase_t                    phase_reg, phase_next;
    logic [hld_pkg::LENGTH_BITS-1:0]    len_reg, len_next;
    logic [hld_pkg::LENGTH_BITS-1:0]    rem_reg, rem_next;
    logic [7:0]                         xor_reg, xor_next;

    hld_pkg::phase_t                    phase_cur;
    logic [hld_pkg::LENGTH_BITS-1:0]    len_cur;
    logic [hld_pkg::LENGTH_BITS-1:0]    rem_cur;
    logic [hld_pkg::LENGTH_BITS-1:0]    rem_dec;
    logic [7:0]                         xor_cur;
    logic [15:0]                        len_full;
    logic [hld_pkg::LENGTH_BITS-1:0]    len_new;

    // restart drops the partial frame before this beat is examined
    assign phase_cur = step.restart ? hld_pkg::PH_HUNT : phase_reg;
    assign len_cur   = step.restart ? '0 : len_reg;
    assign rem_cur   = step.restart ? '0 : rem_reg;
    assign xor_cur   = step.restart ? 8'h00 : xor_reg;

    assign rem_dec  = rem_cur - hld_pkg::LENGTH_BITS'(1);
    assign len_full = {step.data, len_cur[7:0]};
    assign len_new  = len_full[hld_pkg::LENGTH_BITS-1:0];

    always_comb
    begin
        phase_next = phase_cur;
        len_next   = len_cur;
        rem_next   = rem_cur;
        xor_next   = xor_cur;
        res_valid  = 1'b0;
        res.frame_status      = (step.data != xor_cur);
        res.payload_length    = 16'(len_cur);
        res.computed_checksum = xor_cur;
        unique case (phase_cur)
            hld_pkg::PH_HUNT:
            begin
                if (step.data == hld_pkg::SYNC_FIRST)
                begin
                    phase_next = hld_pkg::PH_SYNC2;
                end
            end
            hld_pkg::PH_SYNC2:
            begin
                if (step.data == hld_pkg::SYNC_SECOND)
                begin
                    phase_next = hld_pkg::PH_SKIP_A;
                end
                else if (step.data != hld_pkg::SYNC_FIRST)
                begin
                    phase_next = hld_pkg::PH_HUNT;
                end
            end
            hld_pkg::PH_SKIP_A:
            begin
                phase_next = hld_pkg::PH_SKIP_B;
            end
            hld_pkg::PH_SKIP_B:
            begin
                phase_next = hld_pkg::PH_LEN_LO;
            end
            hld_pkg::PH_LEN_LO:
            begin
                len_next   = hld_pkg::LENGTH_BITS'(step.data);
                xor_next   = step.data;
                phase_next = hld_pkg::PH_LEN_HI;
            end
            hld_pkg::PH_LEN_HI:
            begin
                len_next   = len_new;
                rem_next   = len_new;
                xor_next   = xor_cur ^ step.data;
                phase_next = (len_new == '0) ? hld_pkg::PH_CHECK : hld_pkg::PH_PAYLOAD;
            end
            hld_pkg::PH_PAYLOAD:
            begin
                xor_next = xor_cur ^ step.data;
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = hld_pkg::PH_CHECK;
                end
            end
            hld_pkg::PH_CHECK:
            begin
                res_valid  = step.valid;
                phase_next = hld_pkg::PH_HUNT;
                len_next   = '0;
                rem_next   = '0;
                xor_next   = 8'h00;
            end
            default:
            begin
                phase_next = hld_pkg::PH_HUNT;
                len_next   = '0;
                rem_next   = '0;
                xor_next   = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hld_pkg::PH_HUNT;
            len_reg   <= '0;
            rem_reg   <= '0;
            xor_reg   <= 8'h00;
        end
        else if (step.valid)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

/* rtl/header_length_xor_deframer.sv */
// ----------------------------------------------------------------------------
// header_length_xor_deframer
// Byte stream deframer: sync 0x55 0xAA, two header bytes, 16-bit LE length,
// payload, XOR checksum; one report beat per frame.
//
//  port group  dir  tdata                                   tuser
//  s_axis      in   [7:0] data_byte                         [0] restart
//  m_axis      out  [15:0] payload_length,                  [0] frame_status
//                   [23:16] computed_checksum
//
// One byte per cycle sustained while m_axis accepts. Path: input register,
// parser, result register; a report is registered behind its checksum byte.
// Asynchronous active-low reset puts the parser back to sync hunt.
// A stalled m_axis holds its beat; the input register still takes one
// more byte before s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module header_length_xor_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] payload_length, [23:16] computed_checksum
    output logic        m_axis_tuser    // [0] frame_status
);

    logic               in_valid_reg;
    logic               in_restart_reg;
    logic [7:0]         in_data_reg;
    logic               out_valid_reg;
    hld_pkg::result_t   out_reg;

    logic               advance;
    hld_pkg::step_t     step;
    logic               res_valid;
    hld_pkg::result_t   res;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    assign step.valid   = in_valid_reg && advance;
    assign step.restart = in_restart_reg;
    assign step.data    = in_data_reg;

    hld_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg    <= s_axis_tdata;
            in_restart_reg <= s_axis_tuser;
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.computed_checksum, out_reg.payload_length};
    assign m_axis_tuser  = out_reg.frame_status;

    `ASSERT_IMPLIES(a_restart_no_report, clk, rst_n, in_valid_reg && in_restart_reg, !res_valid, "report on restart beat")
    `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, !s_axis_tready, in_valid_reg && out_valid_reg, "input stalled while a stage is empty")
    `ASSERT_IMPLIES(a_report_from_beat, clk, rst_n, $rose(m_axis_tvalid), $past(in_valid_reg), "report with no byte in flight")

endmodule
